// ===== hdl/magnetometer_compass_heading_macros.svh =====
`ifndef MAGNETOMETER_COMPASS_HEADING_MACROS_SVH
`define MAGNETOMETER_COMPASS_HEADING_MACROS_SVH

// Checks sampled on clk_i, off while rst_ni is low.
`define MCH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: pre at this edge gives post at the next one.
`define MCH_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/mch_pkg.sv =====
package mch_pkg;

  localparam int unsigned WindowDef     = 5;
  localparam int unsigned SampleBitsDef = 16;

  localparam int unsigned FieldW  = 16;
  localparam int unsigned OrientW = 3;
  localparam int unsigned HeadW   = 16;

  // CORDIC vectoring
  localparam int unsigned CordicSteps = 20;
  localparam int unsigned IterW       = 5;
  localparam int unsigned CordW       = 57;
  localparam int unsigned NormBit     = 52;
  localparam int unsigned NormCoarse  = 8;
  localparam int unsigned AngW        = 25;

  // Angle accumulates in 2^-16 degree; heading is in 2^-6 degree
  localparam int unsigned AngFracBits = 10;
  localparam int unsigned RoundBias   = 512;
  localparam int unsigned HeadLimit   = 5760;
  localparam int unsigned HeadFlip    = 11520;

  typedef enum logic [OrientW-1:0] {
    ORIENT_NONE    = 3'd0,
    ORIENT_TOP_UP  = 3'd1,
    ORIENT_TOP_DN  = 3'd2,
    ORIENT_LEFT_UP = 3'd3,
    ORIENT_RIGHT_UP = 3'd4,
    ORIENT_FACE_UP = 3'd5,
    ORIENT_FACE_DN = 3'd6,
    ORIENT_UNKNOWN = 3'd7
  } orient_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_MAP,
    S_NORM,
    S_ROT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic             load;
    logic             acc;
    logic             map;
    logic             norm;
    logic             rot;
    logic [IterW-1:0] iter;
    logic             fin;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic zzero;
    logic norm_done;
  } status_t;

  // atan(2^-i) in 2^-16 degree, rounded to nearest
  function automatic logic [AngW-1:0] atan_step(input logic [IterW-1:0] i);
    logic [AngW-1:0] a;
    unique case (i)
      5'd0:  a = 25'd2949120;
      5'd1:  a = 25'd1740967;
      5'd2:  a = 25'd919879;
      5'd3:  a = 25'd466945;
      5'd4:  a = 25'd234379;
      5'd5:  a = 25'd117304;
      5'd6:  a = 25'd58666;
      5'd7:  a = 25'd29335;
      5'd8:  a = 25'd14668;
      5'd9:  a = 25'd7334;
      5'd10: a = 25'd3667;
      5'd11: a = 25'd1833;
      5'd12: a = 25'd917;
      5'd13: a = 25'd458;
      5'd14: a = 25'd229;
      5'd15: a = 25'd115;
      5'd16: a = 25'd57;
      5'd17: a = 25'd29;
      5'd18: a = 25'd14;
      5'd19: a = 25'd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/mch_if.sv =====
interface mch_in_if import mch_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FieldW-1:0]  mag_x;
  logic signed [FieldW-1:0]  mag_y;
  logic signed [FieldW-1:0]  mag_z;
  logic        [OrientW-1:0] orientation;

  modport source (output valid, mag_x, mag_y, mag_z, orientation, input ready);
  modport sink   (input valid, mag_x, mag_y, mag_z, orientation, output ready);
endinterface

interface mch_out_if import mch_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [HeadW-1:0] heading;

  modport source (output valid, heading, input ready);
  modport sink   (input valid, heading, output ready);
endinterface

// ===== hdl/mch_datapath.sv =====
module mch_datapath import mch_pkg::*; #(
  parameter int unsigned WINDOW      = WindowDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  input  logic signed [FieldW-1:0]  mag_x_i,
  input  logic signed [FieldW-1:0]  mag_y_i,
  input  logic signed [FieldW-1:0]  mag_z_i,
  input  logic        [OrientW-1:0] orientation_i,
  output logic signed [HeadW-1:0]   heading_o
);

  localparam int unsigned SlotW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SumW   = SAMPLE_BITS + $clog2(WINDOW) + 2;
  localparam int unsigned EntryW = 3 * SAMPLE_BITS;

  localparam logic        [SlotW-1:0] LastSlot   = SlotW'(WINDOW - 1);
  localparam logic signed [AngW-1:0]  AngRound   = AngW'(RoundBias);
  localparam logic signed [AngW-1:0]  AngHigh    = AngW'(HeadLimit);
  localparam logic signed [AngW-1:0]  AngLow     = -AngHigh;
  localparam logic signed [HeadW-1:0] HeadOffset = HeadW'(HeadFlip);

  function automatic logic signed [SAMPLE_BITS-1:0] take_sample(input logic [FieldW-1:0] f);
    logic [SAMPLE_BITS+FieldW-1:0] ext;
    ext = {{SAMPLE_BITS{1'b0}}, f};
    return $signed(ext[SAMPLE_BITS-1:0]);
  endfunction

  function automatic logic signed [SumW-1:0] widen(input logic [SAMPLE_BITS-1:0] s);
    return $signed({{(SumW-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s});
  endfunction

  function automatic logic signed [CordW-1:0] to_cord(input logic [SumW-1:0] s);
    return $signed({{(CordW-SumW){s[SumW-1]}}, s});
  endfunction

  // Sample capture and ring
  logic signed [SAMPLE_BITS-1:0] smp_x_q, smp_y_q, smp_z_q;
  orient_e                       orient_q;
  logic [EntryW-1:0]             ring [WINDOW];
  logic [EntryW-1:0]             old_q;
  logic [SlotW-1:0]              slot_q;
  logic                          full_q;
  logic                          wrap;

  logic signed [SumW-1:0] sum_x_q, sum_y_q, sum_z_q;
  logic signed [SumW-1:0] sum_x_d, sum_y_d, sum_z_d;
  logic signed [SumW-1:0] old_x, old_y, old_z;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_x_q  <= take_sample(mag_x_i);
      smp_y_q  <= take_sample(mag_y_i);
      smp_z_q  <= take_sample(mag_z_i);
      orient_q <= orient_e'(orientation_i);
    end
  end

  // Read the entry about to be replaced, then write the new sample over it in the next cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      ring[slot_q] <= {smp_x_q, smp_y_q, smp_z_q};
    end
    if (cmd_i.load) begin
      old_q <= ring[slot_q];
    end
  end

  assign wrap = (slot_q == LastSlot);

  always_comb begin
    if (full_q) begin
      old_x = widen(old_q[EntryW-1 -: SAMPLE_BITS]);
      old_y = widen(old_q[2*SAMPLE_BITS-1 -: SAMPLE_BITS]);
      old_z = widen(old_q[SAMPLE_BITS-1:0]);
    end else begin
      old_x = '0;
      old_y = '0;
      old_z = '0;
    end
    sum_x_d = sum_x_q + widen(smp_x_q) - old_x;
    sum_y_d = sum_y_q + widen(smp_y_q) - old_y;
    sum_z_d = sum_z_q + widen(smp_z_q) - old_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      full_q  <= 1'b0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      sum_z_q <= '0;
    end else if (cmd_i.acc) begin
      slot_q  <= wrap ? '0 : slot_q + 1'b1;
      full_q  <= full_q | wrap;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      sum_z_q <= sum_z_d;
    end
  end

  // Axis remap
  logic signed [SumW-1:0]  hx, hz;
  logic signed [CordW-1:0] hx_w, hz_w;

  always_comb begin
    unique case (orient_q)
      ORIENT_NONE: begin
        hx = sum_x_q;
        hz = sum_z_q;
      end
      ORIENT_TOP_UP, ORIENT_TOP_DN: begin
        hx = sum_x_q;
        hz = -sum_z_q;
      end
      ORIENT_LEFT_UP, ORIENT_RIGHT_UP: begin
        hx = -sum_y_q;
        hz = -sum_z_q;
      end
      ORIENT_FACE_UP, ORIENT_FACE_DN: begin
        hx = -sum_y_q;
        hz = -sum_x_q;
      end
      ORIENT_UNKNOWN: begin
        hx = '0;
        hz = '0;
      end
    endcase
  end

  assign hx_w = to_cord(hx);
  assign hz_w = to_cord(hz);

  // Normalize and rotate
  logic signed [CordW-1:0] u_q, v_q, u_d, v_d;
  logic signed [CordW-1:0] v_abs, mag_max, du, dv;
  logic signed [AngW-1:0]  ang_q, ang_d, step_ang;
  logic                    zneg_q, zzero_q;
  logic                    norm_done, coarse;

  always_comb begin
    v_abs     = v_q[CordW-1] ? -v_q : v_q;
    mag_max   = (v_abs > u_q) ? v_abs : u_q;
    norm_done = |mag_max[CordW-1:NormBit];
    coarse    = ~|mag_max[CordW-1:NormBit-NormCoarse];
    du        = v_q >>> cmd_i.iter;
    dv        = u_q >>> cmd_i.iter;
    step_ang  = $signed(atan_step(cmd_i.iter));
  end

  always_comb begin
    u_d   = u_q;
    v_d   = v_q;
    ang_d = ang_q;
    if (cmd_i.map) begin
      u_d   = hz_w[CordW-1] ? -hz_w : hz_w;
      v_d   = hz_w[CordW-1] ? -hx_w : hx_w;
      ang_d = '0;
    end else if (cmd_i.norm) begin
      if (coarse) begin
        u_d = u_q <<< NormCoarse;
        v_d = v_q <<< NormCoarse;
      end else begin
        u_d = u_q <<< 1;
        v_d = v_q <<< 1;
      end
    end else if (cmd_i.rot) begin
      if (!v_q[CordW-1]) begin
        u_d   = u_q + du;
        v_d   = v_q - dv;
        ang_d = ang_q + step_ang;
      end else begin
        u_d   = u_q - du;
        v_d   = v_q + dv;
        ang_d = ang_q - step_ang;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    v_q   <= v_d;
    ang_q <= ang_d;
    if (cmd_i.map) begin
      zneg_q  <= hz[SumW-1];
      zzero_q <= (hz == '0);
    end
  end

  // Round to 1/64 degree, clamp, unfold the rear half plane
  logic signed [AngW-1:0]  ang_rnd, ang_deg, ang_clip;
  logic signed [HeadW-1:0] head_d;
  logic signed [HeadW-1:0] heading_q;

  always_comb begin
    ang_rnd = ang_q + AngRound;
    ang_deg = ang_rnd >>> AngFracBits;
    if (ang_deg > AngHigh) begin
      ang_clip = AngHigh;
    end else if (ang_deg < AngLow) begin
      ang_clip = AngLow;
    end else begin
      ang_clip = ang_deg;
    end
    head_d = $signed(ang_clip[HeadW-1:0]) + (zneg_q ? HeadOffset : '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      heading_q <= zzero_q ? '0 : head_d;
    end
  end

  assign heading_o          = heading_q;
  assign status_o.full      = full_q | wrap;
  assign status_o.zzero     = (hz == '0);
  assign status_o.norm_done = norm_done;

endmodule

// ===== hdl/mch_ctrl.sv =====
`include "magnetometer_compass_heading_macros.svh"

module mch_ctrl import mch_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e           state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             out_valid_q, out_valid_d;

  localparam logic [IterW-1:0] LastIter = IterW'(CordicSteps - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        state_d = S_ACC;
      end
      S_ACC:  state_d = status_i.full ? S_MAP : S_IDLE;
      S_MAP:  state_d = status_i.zzero ? S_FIN : S_NORM;
      S_NORM: if (status_i.norm_done) begin
        state_d = S_ROT;
      end
      S_ROT:  if (iter_q == LastIter) begin
        state_d = S_FIN;
      end
      S_FIN:  if (!out_valid_q) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    cmd_o.load = in_valid_i && (state_q == S_IDLE);
    cmd_o.acc  = (state_q == S_ACC);
    cmd_o.map  = (state_q == S_MAP);
    cmd_o.norm = (state_q == S_NORM) && !status_i.norm_done;
    cmd_o.rot  = (state_q == S_ROT);
    cmd_o.iter = iter_q;
    // hold the result until the previous heading has been taken
    cmd_o.fin  = (state_q == S_FIN) && !out_valid_q;

    iter_d = (state_q == S_ROT) ? iter_q + 1'b1 : '0;

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.fin) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `MCH_ASSERT(a_iter_range, (state_q != S_ROT) || (iter_q <= LastIter), "CORDIC step past table")
  `MCH_ASSERT_NEXT(a_accept_acc, in_valid_i && in_ready_o, state_q == S_ACC, "transfer not summed")
  `MCH_ASSERT_NEXT(a_norm_rot, (state_q == S_NORM) && status_i.norm_done, (state_q == S_ROT) && (iter_q == '0), "rotation start wrong")
  `MCH_ASSERT_NEXT(a_fin_valid, cmd_o.fin, out_valid_q && (state_q == S_IDLE), "result not posted")

endmodule

// ===== hdl/magnetometer_compass_heading.sv =====
// A sample that completes the window is loaded, summed, remapped, normalized and rotated;
//   zero Z or unknown orientation skips to the result. A new sample is accepted only in
//   idle, after the last heading is posted; samples that only fill the window go back
//   there after summing. The shared shift-add CORDIC unit (20 steps) sets the rate.
// Reset clears the controller, the window sums, write slot and fill flag; ring contents
//   are not cleared, since no entry is used before it is written.
module magnetometer_compass_heading import mch_pkg::*; #(
  parameter int unsigned WINDOW      = WindowDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  mch_in_if.sink     in_i,
  mch_out_if.source  out_o
);

  cmd_t    cmd;
  status_t status;

  mch_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mch_datapath #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .mag_x_i       (in_i.mag_x),
    .mag_y_i       (in_i.mag_y),
    .mag_z_i       (in_i.mag_z),
    .orientation_i (in_i.orientation),
    .heading_o     (out_o.heading)
  );

endmodule
